/* rtl/core/npss_pkg.sv */
package npss_pkg;

    localparam int MAX_SURFACES = 1024;
    localparam int SLOT_W       = $clog2(MAX_SURFACES);
    localparam int CNT_W        = $clog2(MAX_SURFACES + 1);
    localparam int COORD_WIDTH  = 32;
    localparam int CW           = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int CSH          = 32 - CW;

    localparam logic [1:0] CFG_DIM   = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;
    localparam logic [1:0] DIM_2D    = 2'd2;

    typedef enum logic [1:0] {
        OP_VERTEX = 2'd0,
        OP_NORMAL = 2'd1,
        OP_IDENT  = 2'd2,
        OP_QUERY  = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_FDATA,
        ST_FPROD,
        ST_FSUM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              clear_we;
        logic              load;
        logic              start;
        logic              scan_issue;
        logic              ld_v;
        logic              ld_prod;
        logic              ld_sign;
        logic              ld_out;
        logic              use_best;
        logic [SLOT_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic have;
    } t_status;

endpackage

/* rtl/core/npss_ctrl.sv */
module npss_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_opcode,
    input  logic               i_flag,
    input  logic [10:0]        i_count,
    input  logic               i_out_ready,
    input  npss_pkg::t_status  i_status,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output npss_pkg::t_cmd     o_cmd
);

    npss_pkg::t_state r_state, n_state;
    logic [npss_pkg::CNT_W-1:0] r_idx, n_idx;
    logic [1:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic [npss_pkg::CNT_W-1:0] lim;
    logic       accept, out_free, is_query;

    assign lim = (int'(i_count) > npss_pkg::MAX_SURFACES) ?
                 npss_pkg::CNT_W'(npss_pkg::MAX_SURFACES) : npss_pkg::CNT_W'(i_count);
    assign accept   = i_in_valid && (r_state == npss_pkg::ST_IDLE);
    assign is_query = (i_opcode == npss_pkg::OP_QUERY);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            npss_pkg::ST_CLEAR: begin
                if (r_idx == npss_pkg::CNT_W'(npss_pkg::MAX_SURFACES - 1))
                    n_state = npss_pkg::ST_IDLE;
            end
            npss_pkg::ST_IDLE: begin
                if (accept && is_query)
                    n_state = i_flag ? npss_pkg::ST_SCAN : npss_pkg::ST_OUT;
            end
            npss_pkg::ST_SCAN: begin
                if (r_idx >= lim) n_state = npss_pkg::ST_DRAIN;
            end
            npss_pkg::ST_DRAIN: begin
                if (r_cnt == 2'd2)
                    n_state = i_status.have ? npss_pkg::ST_FETCH : npss_pkg::ST_OUT;
            end
            npss_pkg::ST_FETCH: n_state = npss_pkg::ST_FDATA;
            npss_pkg::ST_FDATA: n_state = npss_pkg::ST_FPROD;
            npss_pkg::ST_FPROD: n_state = npss_pkg::ST_FSUM;
            npss_pkg::ST_FSUM:  n_state = npss_pkg::ST_OUT;
            npss_pkg::ST_OUT: begin
                if (out_free) n_state = npss_pkg::ST_IDLE;
            end
            default: n_state = npss_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.addr       = r_idx[npss_pkg::SLOT_W-1:0];
        o_in_ready       = (r_state == npss_pkg::ST_IDLE);
        n_idx            = r_idx;
        n_cnt            = 2'd0;
        n_out_valid      = r_out_valid && !i_out_ready;
        case (r_state)
            npss_pkg::ST_CLEAR: begin
                o_cmd.clear_we = 1'b1;
                n_idx          = r_idx + 1'b1;
            end
            npss_pkg::ST_IDLE: begin
                n_idx       = '0;
                o_cmd.load  = accept && !is_query;
                o_cmd.start = accept && is_query;
            end
            npss_pkg::ST_SCAN: begin
                if (r_idx < lim) begin
                    o_cmd.scan_issue = 1'b1;
                    n_idx            = r_idx + 1'b1;
                end
            end
            npss_pkg::ST_DRAIN: n_cnt = r_cnt + 1'b1;
            npss_pkg::ST_FETCH: o_cmd.use_best = 1'b1;
            npss_pkg::ST_FDATA: o_cmd.ld_v     = 1'b1;
            npss_pkg::ST_FPROD: o_cmd.ld_prod  = 1'b1;
            npss_pkg::ST_FSUM:  o_cmd.ld_sign  = 1'b1;
            npss_pkg::ST_OUT: begin
                if (out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_out_valid  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= npss_pkg::ST_CLEAR;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/npss_dpath.sv */
module npss_dpath (
    input  logic                        i_clk,
    input  npss_pkg::t_cmd              i_cmd,
    input  logic                        i_two_d,
    input  logic [1:0]                  i_opcode,
    input  logic [9:0]                  i_slot,
    input  logic [1:0]                  i_vsel,
    input  logic [31:0]                 i_ax,
    input  logic [31:0]                 i_ay,
    input  logic [31:0]                 i_az,
    input  logic [31:0]                 i_bx,
    input  logic [31:0]                 i_by,
    input  logic [31:0]                 i_bz,
    input  logic [31:0]                 i_ident,
    input  logic                        i_flag,
    output npss_pkg::t_status           o_status,
    output logic                        o_found,
    output logic [31:0]                 o_distance,
    output logic [9:0]                  o_slot,
    output logic [31:0]                 o_ident,
    output logic signed [15:0]          o_nx,
    output logic signed [15:0]          o_ny,
    output logic signed [15:0]          o_nz
);

    function automatic logic signed [31:0] coord(input logic [31:0] v);
        logic signed [31:0] t;
        t = signed'(v << npss_pkg::CSH);
        return t >>> npss_pkg::CSH;
    endfunction

    function automatic logic [15:0] flip16(input logic signed [15:0] v);
        if (v == 16'sh8000) return 16'h7FFF;
        return 16'(-v);
    endfunction

    logic [95:0] mem_p1 [npss_pkg::MAX_SURFACES];
    logic [95:0] mem_p2 [npss_pkg::MAX_SURFACES];
    logic [95:0] mem_p3 [npss_pkg::MAX_SURFACES];
    logic [47:0] mem_n  [npss_pkg::MAX_SURFACES];
    logic [32:0] mem_id [npss_pkg::MAX_SURFACES];

    logic [95:0] r_rd_p1, r_rd_p2, r_rd_p3;
    logic [47:0] r_rd_n;
    logic [32:0] r_rd_id;

    logic [npss_pkg::SLOT_W-1:0] wa, ra;
    logic slot_ok, we_v1, we_v2, we_v3, we_n, we_id;
    logic [32:0] id_wd;

    assign slot_ok = int'(i_slot) < npss_pkg::MAX_SURFACES;
    assign wa      = i_cmd.clear_we ? i_cmd.addr : npss_pkg::SLOT_W'(i_slot);
    assign we_v1   = i_cmd.load && slot_ok && (i_opcode == npss_pkg::OP_VERTEX) && (i_vsel == 2'd0);
    assign we_v2   = i_cmd.load && slot_ok && (i_opcode == npss_pkg::OP_VERTEX) && (i_vsel == 2'd1);
    assign we_v3   = i_cmd.load && slot_ok && (i_opcode == npss_pkg::OP_VERTEX) && (i_vsel == 2'd2);
    assign we_n    = i_cmd.load && slot_ok && (i_opcode == npss_pkg::OP_NORMAL);
    assign we_id   = i_cmd.clear_we ||
                     (i_cmd.load && slot_ok && (i_opcode == npss_pkg::OP_IDENT));
    assign id_wd   = i_cmd.clear_we ? 33'd0 : {i_flag, i_ident};

    logic [npss_pkg::SLOT_W-1:0] r_best;
    assign ra = i_cmd.use_best ? r_best : i_cmd.addr;

    always_ff @(posedge i_clk) begin
        if (we_v1) mem_p1[wa] <= {i_az, i_ay, i_ax};
        if (we_v2) mem_p2[wa] <= {i_az, i_ay, i_ax};
        if (we_v3) mem_p3[wa] <= {i_az, i_ay, i_ax};
        if (we_n)  mem_n[wa]  <= {i_az[15:0], i_ay[15:0], i_ax[15:0]};
        if (we_id) mem_id[wa] <= id_wd;
        r_rd_p1 <= mem_p1[ra];
        r_rd_p2 <= mem_p2[ra];
        r_rd_p3 <= mem_p3[ra];
        r_rd_n  <= mem_n[ra];
        r_rd_id <= mem_id[ra];
    end

    // doubled cell centre
    logic signed [32:0] r_ctr2 [3];
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ctr2[0] <= 33'(coord(i_ax)) + 33'(coord(i_bx));
            r_ctr2[1] <= 33'(coord(i_ay)) + 33'(coord(i_by));
            r_ctr2[2] <= 33'(coord(i_az)) + 33'(coord(i_bz));
        end
    end

    // scan pipeline: read, product, sum, compare
    logic                        r_v1, r_v2, r_v3;
    logic [npss_pkg::SLOT_W-1:0] r_s1, r_s2, r_s3;
    logic signed [49:0]          r_prod [3];
    logic signed [51:0]          r_dot;
    logic [51:0]                 r_best_abs, dot_abs;
    logic                        r_have;
    logic signed [33:0]          sd [3];
    logic signed [15:0]          rn [3];
    logic signed [31:0]          p1 [3], p2 [3], p3 [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            p1[c] = coord(r_rd_p1[32*c +: 32]);
            p2[c] = coord(r_rd_p2[32*c +: 32]);
            p3[c] = coord(r_rd_p3[32*c +: 32]);
            rn[c] = signed'(r_rd_n[16*c +: 16]);
            sd[c] = 34'(r_ctr2[c]) - (34'(p1[c]) <<< 1);
        end
    end

    assign dot_abs = r_dot[51] ? 52'(-r_dot) : 52'(r_dot);

    always_ff @(posedge i_clk) begin
        r_v1 <= i_cmd.scan_issue;
        r_s1 <= i_cmd.addr;
        r_v2 <= r_v1 && r_rd_id[32];
        r_s2 <= r_s1;
        for (int c = 0; c < 3; c++)
            r_prod[c] <= 50'(sd[c]) * 50'(rn[c]);
        r_v3 <= r_v2;
        r_s3 <= r_s2;
        r_dot <= 52'(r_prod[0]) + 52'(r_prod[1]) + (i_two_d ? 52'sd0 : 52'(r_prod[2]));
        if (i_cmd.start) begin
            r_have <= 1'b0;
        end else if (r_v3 && (!r_have || dot_abs < r_best_abs)) begin
            r_have     <= 1'b1;
            r_best_abs <= dot_abs;
            r_best     <= r_s3;
        end
    end

    assign o_status.have = r_have;

    // orientation of the winning normal
    logic signed [35:0] r_ov [3];
    logic signed [15:0] r_nv [3];
    logic [31:0]        r_fid;
    logic signed [51:0] r_oprod [3];
    logic               r_neg;
    logic signed [53:0] osum;

    assign osum = 54'(r_oprod[0]) + 54'(r_oprod[1]) + 54'(r_oprod[2]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_v) begin
            r_fid <= r_rd_id[31:0];
            for (int c = 0; c < 3; c++) begin
                if (i_two_d) begin
                    r_ov[c] <= 36'(r_ctr2[c]) - 36'(p1[c]) - 36'(p2[c]);
                    r_nv[c] <= (c == 2) ? 16'sd0 : rn[c];
                end else begin
                    r_ov[c] <= 36'(r_ctr2[c]) * 36'sd3
                             - ((36'(p1[c]) + 36'(p2[c]) + 36'(p3[c])) <<< 1);
                    r_nv[c] <= rn[c];
                end
            end
        end
        if (i_cmd.ld_prod) begin
            for (int c = 0; c < 3; c++)
                r_oprod[c] <= 52'(r_ov[c]) * 52'(r_nv[c]);
        end
        if (i_cmd.ld_sign) r_neg <= osum[53];
    end

    // result register
    logic [52:0] rnd;
    logic [37:0] rsh;
    assign rnd = {1'b0, r_best_abs} + 53'd16384;
    assign rsh = rnd[52:15];

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            if (r_have) begin
                o_found    <= 1'b1;
                o_distance <= (|rsh[37:32]) ? 32'hFFFF_FFFF : rsh[31:0];
                o_slot     <= 10'(r_best);
                o_ident    <= r_fid;
                o_nx       <= r_neg ? signed'(flip16(r_nv[0])) : r_nv[0];
                o_ny       <= r_neg ? signed'(flip16(r_nv[1])) : r_nv[1];
                o_nz       <= r_neg ? signed'(flip16(r_nv[2])) : r_nv[2];
            end else begin
                o_found    <= 1'b0;
                o_distance <= 32'hFFFF_FFFF;
                o_slot     <= '0;
                o_ident    <= '0;
                o_nx       <= '0;
                o_ny       <= '0;
                o_nz       <= '0;
            end
        end
    end

endmodule

/* rtl/core/nearest_plane_surface_search.sv */
// Nearest plane surface search. Load requests (vertex, normal, id/eligible) are
// accepted while idle, with no wait between them. A query request scans surface
// slots 0 to count-1, with count = min(surface_count, 1024), through one read port
// of the surface table, one slot per cycle. After the scan the block drains its
// pipeline and, if a surface is found, fetches the winner and orients its normal
// before output; a query with its flag bit clear skips the scan. The block handles
// one query at a time and holds its input while a finished result waits behind an
// unaccepted one. After reset the eligible bits of all slots are cleared, during
// which no request is accepted; configuration writes are taken at any time.
module nearest_plane_surface_search (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // slot[9:0] vertex_select[11:10] ax[43:12] ay[75:44] az[107:76] bx[139:108]
    // by[171:140] bz[203:172] surface_ident[235:204] flag_bit[236], zero fill
    input  logic [239:0] i_s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // found[0] distance[32:1] nearest_slot[42:33] nearest_ident[74:43]
    // normal_x[90:75] normal_y[106:91] normal_z[122:107], zero fill
    output logic [127:0] o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [10:0]  i_cfg_wdata
);

    logic [1:0]  r_dim;
    logic [10:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim   <= 2'd3;
            r_count <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == npss_pkg::CFG_DIM)   r_dim   <= i_cfg_wdata[1:0];
            if (i_cfg_index == npss_pkg::CFG_COUNT) r_count <= i_cfg_wdata;
        end
    end

    npss_pkg::t_cmd    cmd;
    npss_pkg::t_status status;
    logic              found;
    logic [31:0]       distance, nident;
    logic [9:0]        nslot;
    logic signed [15:0] nx, ny, nz;

    npss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_opcode    (i_s_axis_tuser),
        .i_flag      (i_s_axis_tdata[236]),
        .i_count     (r_count),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    npss_dpath u_dpath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_two_d    (r_dim == npss_pkg::DIM_2D),
        .i_opcode   (i_s_axis_tuser),
        .i_slot     (i_s_axis_tdata[9:0]),
        .i_vsel     (i_s_axis_tdata[11:10]),
        .i_ax       (i_s_axis_tdata[43:12]),
        .i_ay       (i_s_axis_tdata[75:44]),
        .i_az       (i_s_axis_tdata[107:76]),
        .i_bx       (i_s_axis_tdata[139:108]),
        .i_by       (i_s_axis_tdata[171:140]),
        .i_bz       (i_s_axis_tdata[203:172]),
        .i_ident    (i_s_axis_tdata[235:204]),
        .i_flag     (i_s_axis_tdata[236]),
        .o_status   (status),
        .o_found    (found),
        .o_distance (distance),
        .o_slot     (nslot),
        .o_ident    (nident),
        .o_nx       (nx),
        .o_ny       (ny),
        .o_nz       (nz)
    );

    assign o_m_axis_tdata = {5'd0, nz, ny, nx, nident, nslot, distance, found};

endmodule
